@@ design/vdrh_pkg.sv @@
// ----------------------------------------------------------------------------
// vdrh_pkg
// Types, register codes and helper functions of the rate-1/2 Viterbi decoder.
// ----------------------------------------------------------------------------
package vdrh_pkg;

  localparam int METRIC_W   = 24;
  localparam int BM_W       = 16;
  localparam int COST_W     = METRIC_W + 1;
  localparam int POLY_W     = 5;
  localparam int DELAY_W    = 6;
  localparam int BEST_W     = 4;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  localparam logic [METRIC_W-1:0] METRIC_MAX  = '1;
  localparam logic [METRIC_W-1:0] METRIC_INIT = 24'd10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLY_A    = 8'd0,
    CFG_POLY_B    = 8'd1,
    CFG_OUT_DELAY = 8'd2,
    CFG_INVERT    = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [BM_W-1:0] metric_sym0;
    logic [BM_W-1:0] metric_sym1;
    logic [BM_W-1:0] metric_sym2;
    logic [BM_W-1:0] metric_sym3;
  } in_t;

  typedef struct packed {
    logic              decoded_bit;
    logic [BEST_W-1:0] best_state_index;
  } out_t;

  // expected code symbol of a branch: {parity(poly_a & br), parity(poly_b & br)}
  function automatic logic [1:0] branch_sym(logic [POLY_W-1:0] pa, logic [POLY_W-1:0] pb,
                                            logic [7:0] br);
    logic [7:0] ma;
    logic [7:0] mb;
    ma = {3'b000, pa} & br;
    mb = {3'b000, pb} & br;
    return {^ma, ^mb};
  endfunction

  function automatic logic [BM_W-1:0] sym_metric(in_t d, logic [1:0] sym);
    logic [BM_W-1:0] m;
    unique case (sym)
      2'd0:    m = d.metric_sym0;
      2'd1:    m = d.metric_sym1;
      2'd2:    m = d.metric_sym2;
      default: m = d.metric_sym3;
    endcase
    return m;
  endfunction

endpackage

@@ design/viterbi_decoder_rate_half_core.sv @@
// ----------------------------------------------------------------------------
// viterbi_decoder_rate_half_core
// Rate-1/2 Viterbi decoder; path metrics and histories in ping-pong memories.
// ----------------------------------------------------------------------------
//  channel | ports                              | transaction
//  --------+------------------------------------+-------------------------------
//  in      | in_valid, in_ready, in_data        | four branch metrics
//  out     | out_valid, out_ready, out_data     | decoded bit, best state index
//  cfg     | cfg_valid, cfg_ready, cfg_index,   | one register write
//          | cfg_data                           |
//
//  An item runs a min pass reading one state per cycle, then an update pass of one
//  state per cycle through a two-stage add/compare-select pipe, which reads both
//  predecessor rows of each state through the two read ports of the metric memory.
//  Reset is synchronous; the first item after reset reads reset metrics by a flag,
//  no clearing pass. in_ready is high in idle, also while a result waits on out.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module viterbi_decoder_rate_half_core #(
  parameter int CONSTRAINT_BITS = 5,
  parameter int HISTORY_BITS    = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  vdrh_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output vdrh_pkg::out_t                   out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [vdrh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vdrh_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import vdrh_pkg::*;

  localparam int NS     = 1 << (CONSTRAINT_BITS - 1);
  localparam int SW     = CONSTRAINT_BITS - 1;
  localparam int HALF_S = NS / 2;
  localparam int CNT_W  = SW + 1;
  localparam int HIW    = $clog2(HISTORY_BITS);
  localparam int AW     = SW + 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MIN  = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  // memories
  logic [METRIC_W-1:0]     pm_mem   [2*NS];
  logic [HISTORY_BITS-1:0] hist_mem [2*NS];

  logic [METRIC_W-1:0]     pm_qa_r, pm_qb_r;
  logic [HISTORY_BITS-1:0] hist_qa_r, hist_qb_r;
  logic [SW-1:0]           qidx_a_r;

  logic [AW-1:0]           rd_addr_a, rd_addr_b, wr_addr;
  logic                    wr_en;
  logic [METRIC_W-1:0]     wr_pm;
  logic [HISTORY_BITS-1:0] wr_hist;

  // control
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                a_vld_r, a_vld_nxt;
  logic                b1_vld_r, b1_vld_nxt;
  logic                b2_vld_r, b2_vld_nxt;
  logic                bank_r, bank_nxt;
  logic                fresh_r, fresh_nxt;
  logic [COST_W-1:0]   min_r, min_nxt;
  logic [SW-1:0]       best_r, best_nxt;
  logic                bit_r, bit_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [POLY_W-1:0]   poly_a_r, poly_a_nxt;
  logic [POLY_W-1:0]   poly_b_r, poly_b_nxt;
  logic [DELAY_W-1:0]  delay_r, delay_nxt;
  logic                invert_r, invert_nxt;

  // payload
  in_t                     in_r;
  logic [SW-1:0]           a_idx_r, b1_j_r, b2_j_r;
  logic [COST_W-1:0]       c0_r, c1_r, c0_nxt, c1_nxt;
  logic [HISTORY_BITS-1:0] h0_r, h1_r, h0_nxt, h1_nxt;
  out_t                    out_r, out_nxt;
  logic                    out_load;

  // datapath
  logic [SW-1:0]           p0, p1;
  logic [METRIC_W-1:0]     pm_a_val, pm_b_val;
  logic [HISTORY_BITS-1:0] hist_a_val, hist_b_val;
  logic [CONSTRAINT_BITS-1:0] br_0, br_1;
  logic [COST_W-1:0]       cost_0, cost_1, min_step;
  logic [SW-1:0]           best_step;
  logic                    take_hi;
  logic [COST_W-1:0]       c_pick, c_diff;
  logic [HISTORY_BITS-1:0] h_pick, hist_new;
  logic                    delay_ok, sel_bit;
  logic [7:0]              best_ext;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign p0 = cnt_r[SW-1:0] >> 1;
  assign p1 = p0 | SW'(HALF_S);

  assign rd_addr_a = (state_r == ST_MIN) ? {bank_r, cnt_r[SW-1:0]} : {bank_r, p0};
  assign rd_addr_b = {bank_r, p1};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pm_mem[wr_addr]   <= wr_pm;
      hist_mem[wr_addr] <= wr_hist;
    end
    pm_qa_r   <= pm_mem[rd_addr_a];
    pm_qb_r   <= pm_mem[rd_addr_b];
    hist_qa_r <= hist_mem[rd_addr_a];
    hist_qb_r <= hist_mem[rd_addr_b];
    qidx_a_r  <= rd_addr_a[SW-1:0];
  end

  // before the first update, reset values stand in for what the old bank holds
  always_comb begin
    if (fresh_r) begin
      pm_a_val   = (qidx_a_r == '0) ? '0 : METRIC_INIT;
      pm_b_val   = METRIC_INIT;
      hist_a_val = '0;
      hist_b_val = '0;
    end else begin
      pm_a_val   = pm_qa_r;
      pm_b_val   = pm_qb_r;
      hist_a_val = hist_qa_r;
      hist_b_val = hist_qb_r;
    end
  end

  // branch costs: min pass uses {s,0},{s,1}; update pass uses {0,j},{1,j}
  always_comb begin
    if (state_r == ST_MIN) begin
      br_0 = {a_idx_r, 1'b0};
      br_1 = {a_idx_r, 1'b1};
    end else begin
      br_0 = {1'b0, b1_j_r};
      br_1 = {1'b1, b1_j_r};
    end
    cost_0 = COST_W'(pm_a_val)
           + COST_W'(sym_metric(in_r, branch_sym(poly_a_r, poly_b_r, 8'(br_0))));
    cost_1 = ((state_r == ST_MIN) ? COST_W'(pm_a_val) : COST_W'(pm_b_val))
           + COST_W'(sym_metric(in_r, branch_sym(poly_a_r, poly_b_r, 8'(br_1))));
  end

  always_comb begin
    if ((a_idx_r == '0) || (cost_0 < min_r)) begin
      min_step  = cost_0;
      best_step = br_0[SW-1:0];
    end else begin
      min_step  = min_r;
      best_step = best_r;
    end
    if (cost_1 < min_step) begin
      min_step  = cost_1;
      best_step = br_1[SW-1:0];
    end
  end

  // compare-select, normalize, saturate
  always_comb begin
    take_hi  = !(c0_r < c1_r);
    c_pick   = take_hi ? c1_r : c0_r;
    h_pick   = take_hi ? h1_r : h0_r;
    c_diff   = c_pick - min_r;
    hist_new = {h_pick[HISTORY_BITS-2:0], b2_j_r[0]};
    delay_ok = ({1'b0, delay_r} < (DELAY_W+1)'(HISTORY_BITS));
    sel_bit  = delay_ok ? hist_new[delay_r[HIW-1:0]] : 1'b0;
    wr_en    = b2_vld_r;
    wr_addr  = {~bank_r, b2_j_r};
    wr_pm    = c_diff[COST_W-1] ? METRIC_MAX : c_diff[METRIC_W-1:0];
    wr_hist  = hist_new;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    a_vld_nxt     = 1'b0;
    b1_vld_nxt    = 1'b0;
    b2_vld_nxt    = b1_vld_r;
    bank_nxt      = bank_r;
    fresh_nxt     = fresh_r;
    min_nxt       = min_r;
    best_nxt      = best_r;
    bit_nxt       = bit_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_load      = 1'b0;
    poly_a_nxt    = poly_a_r;
    poly_b_nxt    = poly_b_r;
    delay_nxt     = delay_r;
    invert_nxt    = invert_r;
    c0_nxt        = cost_0;
    c1_nxt        = cost_1;
    h0_nxt        = hist_a_val;
    h1_nxt        = hist_b_val;

    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_POLY_A:    poly_a_nxt = cfg_data[POLY_W-1:0];
        CFG_POLY_B:    poly_b_nxt = cfg_data[POLY_W-1:0];
        CFG_OUT_DELAY: delay_nxt  = cfg_data[DELAY_W-1:0];
        CFG_INVERT:    invert_nxt = cfg_data[0];
        default: ;
      endcase
    end

    if (a_vld_r) begin
      min_nxt  = min_step;
      best_nxt = best_step;
    end

    if (b2_vld_r && (b2_j_r == best_r)) begin
      bit_nxt = sel_bit ^ invert_r;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cnt_nxt   = '0;
          state_nxt = ST_MIN;
        end
      end
      ST_MIN: begin
        if (cnt_r < CNT_W'(NS)) begin
          a_vld_nxt = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
        end else begin
          cnt_nxt   = '0;
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (cnt_r < CNT_W'(NS)) begin
          b1_vld_nxt = 1'b1;
          cnt_nxt    = cnt_r + 1'b1;
        end
        if (b2_vld_r && (b2_j_r == SW'(NS - 1))) begin
          bank_nxt  = ~bank_r;
          fresh_nxt = 1'b0;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    best_ext                 = 8'(best_r);
    out_nxt.decoded_bit      = bit_r;
    out_nxt.best_state_index = best_ext[BEST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      a_vld_r     <= 1'b0;
      b1_vld_r    <= 1'b0;
      b2_vld_r    <= 1'b0;
      bank_r      <= 1'b0;
      fresh_r     <= 1'b1;
      min_r       <= '0;
      best_r      <= '0;
      bit_r       <= 1'b0;
      out_valid_r <= 1'b0;
      poly_a_r    <= '0;
      poly_b_r    <= '0;
      delay_r     <= '0;
      invert_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      a_vld_r     <= a_vld_nxt;
      b1_vld_r    <= b1_vld_nxt;
      b2_vld_r    <= b2_vld_nxt;
      bank_r      <= bank_nxt;
      fresh_r     <= fresh_nxt;
      min_r       <= min_nxt;
      best_r      <= best_nxt;
      bit_r       <= bit_nxt;
      out_valid_r <= out_valid_nxt;
      poly_a_r    <= poly_a_nxt;
      poly_b_r    <= poly_b_nxt;
      delay_r     <= delay_nxt;
      invert_r    <= invert_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    a_idx_r <= cnt_r[SW-1:0];
    b1_j_r  <= cnt_r[SW-1:0];
    b2_j_r  <= b1_j_r;
    c0_r    <= c0_nxt;
    c1_r    <= c1_nxt;
    h0_r    <= h0_nxt;
    h1_r    <= h1_nxt;
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  // every branch cost seen by the select stage is at or above the pass minimum
  a_cost_above_min: assert property (@(posedge clk) disable iff (!rst_n)
    b2_vld_r |-> ((c0_r >= min_r) && (c1_r >= min_r)))
    else $error("branch cost below minimum");

  a_min_in_min_pass: assert property (@(posedge clk) disable iff (!rst_n)
    a_vld_r |-> (state_r == ST_MIN))
    else $error("min pipe active outside min pass");

  a_write_in_upd: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == ST_UPD))
    else $error("memory write outside update pass");

  a_bank_flip: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(bank_r) |-> ($past(state_r) == ST_UPD) && (state_r == ST_DONE))
    else $error("bank flip outside end of update");

  a_fresh_once: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(fresh_r) |-> 1'b0)
    else $error("reset-metric flag set again");

endmodule

@@ bench/viterbi_decoder_rate_half_core_tb.sv @@
// ----------------------------------------------------------------------------
// viterbi_decoder_rate_half_core_tb
// Self-checking bench for the rate-1/2 Viterbi decoder core. A clocked driver
// feeds branch-metric transactions from a queue and a clocked monitor checks
// every decision against a cycle-free add-compare-select model. Stimulus runs
// under several polynomial, delay and inversion settings. It mixes a directed
// set, symbols from a small convolutional encoder with noise, plain random
// metrics and metric ties. Both sides stall at random.
// ----------------------------------------------------------------------------
module viterbi_decoder_rate_half_core_tb;
  import vdrh_pkg::*;

  localparam int K         = 5;
  localparam int NUM_BR    = 1 << K;
  localparam int NUM_ST    = NUM_BR / 2;
  localparam int HIST_BITS = 64;
  localparam int LIMIT     = 400_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  viterbi_decoder_rate_half_core #(
    .CONSTRAINT_BITS(K),
    .HISTORY_BITS(HIST_BITS)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // decoder model state
  logic [METRIC_W-1:0] pm_model [NUM_ST];
  logic [HIST_BITS-1:0] hist_model [NUM_ST];
  logic [POLY_W-1:0] poly_a_q = '0;
  logic [POLY_W-1:0] poly_b_q = '0;
  logic [DELAY_W-1:0] delay_q = '0;
  logic invert_q = 1'b0;

  in_t metric_items [$];
  out_t want_decisions [$];
  logic [3:0] enc_reg = '0;
  bit calm = 1'b0;
  int errors = 0;
  int items_sent = 0;
  int decisions_seen = 0;
  int settings_used = 1;
  int cycles = 0;
  logic [NUM_ST-1:0] best_seen = '0;
  logic [1:0] bit_seen = '0;

  initial begin
    for (int s = 0; s < NUM_ST; s++) begin
      pm_model[s] = (s == 0) ? '0 : METRIC_INIT;
      hist_model[s] = '0;
    end
  end

  function automatic out_t acs_step(in_t d);
    logic [COST_W-1:0] cost [NUM_BR];
    logic [HIST_BITS-1:0] cand [NUM_BR];
    logic [COST_W-1:0] minv;
    logic [COST_W-1:0] diff;
    logic [POLY_W-1:0] br;
    logic [1:0] sym;
    logic [BM_W-1:0] bm;
    logic [BEST_W-1:0] best;
    logic hbit;
    int minb;
    int pick;
    out_t r;
    minv = '0;
    minb = 0;
    for (int i = 0; i < NUM_BR; i++) begin
      br = POLY_W'(i);
      sym = {^(poly_a_q & br), ^(poly_b_q & br)};
      case (sym)
        2'd0: bm = d.metric_sym0;
        2'd1: bm = d.metric_sym1;
        2'd2: bm = d.metric_sym2;
        default: bm = d.metric_sym3;
      endcase
      cost[i] = {1'b0, pm_model[i / 2]} + COST_W'(bm);
      if (i == 0 || cost[i] < minv) begin
        minv = cost[i];
        minb = i;
      end
      cand[i] = {hist_model[i / 2][HIST_BITS-2:0], br[0]};
    end
    best = BEST_W'(minb % NUM_ST);
    for (int j = 0; j < NUM_ST; j++) begin
      pick = (cost[j] < cost[j + NUM_ST]) ? j : j + NUM_ST;
      diff = cost[pick] - minv;
      pm_model[j] = (diff > COST_W'(METRIC_MAX)) ? METRIC_MAX : diff[METRIC_W-1:0];
      hist_model[j] = cand[pick];
    end
    hbit = (int'(delay_q) < HIST_BITS) ? hist_model[best][delay_q] : 1'b0;
    r.decoded_bit = hbit ^ invert_q;
    r.best_state_index = best;
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        want_decisions.push_back(acs_step(in_data));
        items_sent++;
      end
      if (!in_valid || in_ready) begin
        if (metric_items.size() != 0 && (calm || $urandom_range(99) >= 28)) begin
          in_valid <= 1'b1;
          in_data <= metric_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : mon
    out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (want_decisions.size() == 0) begin
          flag_mismatch($sformatf("unexpected transaction bit=%0b best=%0d",
                                  out_data.decoded_bit, out_data.best_state_index));
        end else begin
          want = want_decisions.pop_front();
          decisions_seen++;
          if (out_data.decoded_bit !== want.decoded_bit)
            flag_mismatch($sformatf("#%0d decoded_bit exp %0b got %0b", decisions_seen,
                                    want.decoded_bit, out_data.decoded_bit));
          if (out_data.best_state_index !== want.best_state_index)
            flag_mismatch($sformatf("#%0d best_state_index exp %0d got %0d", decisions_seen,
                                    want.best_state_index, out_data.best_state_index));
          best_seen[want.best_state_index] = 1'b1;
          bit_seen[want.decoded_bit] = 1'b1;
        end
      end
      out_ready <= calm || ($urandom_range(99) >= 28);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d decisions pending", cycles,
               want_decisions.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_POLY_A:    poly_a_q = val[POLY_W-1:0];
      CFG_POLY_B:    poly_b_q = val[POLY_W-1:0];
      CFG_OUT_DELAY: delay_q = val[DELAY_W-1:0];
      CFG_INVERT:    invert_q = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_config(logic [7:0] pa, logic [7:0] pb, logic [7:0] dl, logic [7:0] iv);
    cfg_write(CFG_POLY_A, pa);
    cfg_write(CFG_POLY_B, pb);
    cfg_write(CFG_OUT_DELAY, dl);
    cfg_write(CFG_INVERT, iv);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic push_item(logic [15:0] m0, logic [15:0] m1, logic [15:0] m2,
                           logic [15:0] m3);
    in_t it;
    it.metric_sym0 = m0;
    it.metric_sym1 = m1;
    it.metric_sym2 = m2;
    it.metric_sym3 = m3;
    metric_items.push_back(it);
  endtask

  task automatic drain();
    while (metric_items.size() != 0 || in_valid || want_decisions.size() != 0)
      @(posedge clk);
  endtask

  task automatic add_random(int n);
    int unsigned amp;
    int unsigned roll;
    int unsigned v;
    logic [POLY_W-1:0] br;
    logic [1:0] sym;
    logic [1:0] flip;
    logic [15:0] m [4];
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      if (roll < 72) begin
        // encoded symbol stream with soft noise and occasional hard errors
        br = {enc_reg, 1'($urandom_range(1))};
        sym = {^(poly_a_q & br), ^(poly_b_q & br)};
        enc_reg = br[3:0];
        if ($urandom_range(9) == 0) sym ^= 2'($urandom_range(1, 3));
        amp = ($urandom_range(3) == 0) ? $urandom_range(16384, 32767) : $urandom_range(1, 2000);
        for (int s = 0; s < 4; s++) begin
          flip = 2'(s) ^ sym;
          v = (int'(flip[0]) + int'(flip[1])) * amp + $urandom_range(0, amp);
          m[s] = (v > 65535) ? 16'hFFFF : 16'(v);
        end
      end else if (roll < 90) begin
        for (int s = 0; s < 4; s++) m[s] = 16'($urandom);
      end else begin
        v = $urandom_range(65535);
        for (int s = 0; s < 4; s++) m[s] = 16'(v);
        if ($urandom_range(1) == 1) m[$urandom_range(3)] = 16'($urandom);
      end
      push_item(m[0], m[1], m[2], m[3]);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: every branch expects symbol 00
    push_item(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    push_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_item(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_item(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    drain();

    apply_config(8'd19, 8'd29, 8'd0, 8'd0);
    push_item(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_item(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
    push_item(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
    push_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    push_item(16'd1234, 16'd1234, 16'd1234, 16'd1234);
    push_item(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    push_item(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    push_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_item(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    push_item(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
    push_item(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
    push_item(16'h0001, 16'h0001, 16'h0000, 16'h0000);
    drain();

    apply_config(8'd19, 8'd29, 8'd63, 8'd1);
    calm = 1'b1;
    add_random(200);
    drain();
    calm = 1'b0;

    apply_config(8'd31, 8'd31, 8'd5, 8'd0);
    add_random(160);
    drain();

    apply_config(8'd0, 8'd31, 8'd31, 8'd1);
    add_random(160);
    drain();

    for (int p = 0; p < 6; p++) begin
      apply_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      add_random(150);
      drain();
    end

    repeat (45) @(posedge clk);
    $display("covered %0d metric transactions under %0d register settings, %0d checked",
             items_sent, settings_used, decisions_seen);
    $display("best states seen mask %04h, decoded bit values seen %02b, %0d mismatches",
             best_seen, bit_seen, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
